// ===== rtl/opd_pkg.sv =====
`default_nettype none

package opd_pkg;

	localparam int MAX_SEGMENTS = 255;
	localparam int SEG_AW       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SCAN_W       = 9;
	localparam int HEADER_BYTES = 23;
	localparam int HDR_IW       = 5;

	// byte positions within the header that follows the capture pattern
	localparam int POS_VERSION  = 0;
	localparam int POS_FLAGS    = 1;
	localparam int POS_GRANULE  = 2;
	localparam int POS_SERIAL   = 10;
	localparam int POS_SEQUENCE = 14;
	localparam int POS_CHECKSUM = 18;
	localparam int POS_COUNT    = 22;

	localparam logic [7:0] CAPTURE [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HEADER,
		PH_TABLE,
		PH_PAYLOAD,
		PH_SCAN_RD,
		PH_SCAN_CHK
	} phase_t;

	typedef enum logic [1:0] {
		EV_HEADER,
		EV_DONE,
		EV_PAYLOAD,
		EV_BADSIG
	} ev_t;

	typedef enum logic [1:0] {
		SIG_HOLD,
		SIG_ADV,
		SIG_CLR,
		SIG_BAD
	} sig_op_t;

	typedef struct packed {
		logic    take;
		ev_t     ev;
		logic    eos;
		sig_op_t sig_op;
		logic    hdr_wr;
		logic    tbl_wr;
		logic    pay_dec;
		logic    scan_start;
		logic    scan_from_next;
		logic    scan_rd;
		logic    scan_adv;
		logic    scan_hit;
		logic    clear;
	} cmd_t;

	typedef struct packed {
		logic sig_match;
		logic sig_last;
		logic byte_zero;
		logic hdr_last;
		logic tbl_last;
		logic seg_end;
		logic scan_end;
		logic scan_hit;
	} stat_t;

	// last member sits in the lowest bits
	typedef struct packed {
		logic [31:0] bytes_consumed;
		logic [7:0]  segment_count;
		logic [31:0] checksum;
		logic [31:0] sequence_number;
		logic [31:0] serial_number;
		logic [63:0] granule_position;
		logic [7:0]  header_type;
		logic [7:0]  version;
		logic [7:0]  payload_byte;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/opd_datapath.sv =====
`default_nettype none

module opd_datapath (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [7:0]       data_byte,
	input  opd_pkg::cmd_t    cmd,
	output opd_pkg::stat_t   stat,
	output opd_pkg::res_t    res,
	output logic [1:0]       res_ev,
	output logic             res_eos
);
	import opd_pkg::*;

	logic [1:0]        sig_q, sig_d;
	logic [HDR_IW-1:0] hdr_q, hdr_d;
	logic [7:0]        total_q, total_d;
	logic [7:0]        seg_q, seg_d;
	logic [7:0]        rem_q, rem_d;
	logic [SCAN_W-1:0] scan_q, scan_d;
	logic [SCAN_W-1:0] lim;
	logic [7:0]        ver_q, ver_d;
	logic [7:0]        flags_q, flags_d;
	logic [63:0]       gran_q, gran_d;
	logic [31:0]       serial_q, serial_d;
	logic [31:0]       seqn_q, seqn_d;
	logic [31:0]       crc_q, crc_d;
	logic [31:0]       cnt_q, cnt_d;
	logic [7:0]        rdata_q;
	logic [7:0]        seg_mem [MAX_SEGMENTS];

	assign lim = ({1'b0, total_q} < SCAN_W'(MAX_SEGMENTS)) ? {1'b0, total_q}
	                                                       : SCAN_W'(MAX_SEGMENTS);

	always_comb begin
		stat.sig_match = (data_byte == CAPTURE[sig_q]);
		stat.sig_last  = (sig_q == 2'd3);
		stat.byte_zero = (data_byte == 8'd0);
		stat.hdr_last  = (hdr_q == HDR_IW'(HEADER_BYTES - 1));
		stat.tbl_last  = (({1'b0, seg_q} + 9'd1) >= {1'b0, total_q});
		stat.seg_end   = (rem_q <= 8'd1);
		stat.scan_end  = (scan_q >= lim);
		stat.scan_hit  = (rdata_q != 8'd0);
	end

	always_comb begin
		sig_d    = sig_q;
		hdr_d    = hdr_q;
		total_d  = total_q;
		seg_d    = seg_q;
		rem_d    = rem_q;
		scan_d   = scan_q;
		ver_d    = ver_q;
		flags_d  = flags_q;
		gran_d   = gran_q;
		serial_d = serial_q;
		seqn_d   = seqn_q;
		crc_d    = crc_q;
		cnt_d    = cnt_q;

		case (cmd.sig_op)
			SIG_ADV: sig_d = sig_q + 2'd1;
			SIG_CLR: sig_d = 2'd0;
			// a stray 'O' already starts the next pattern
			SIG_BAD: sig_d = (data_byte == CAPTURE[0]) ? 2'd1 : 2'd0;
			default: sig_d = sig_q;
		endcase

		if (cmd.hdr_wr) begin
			hdr_d = stat.hdr_last ? '0 : hdr_q + HDR_IW'(1);
			if (hdr_q == HDR_IW'(POS_VERSION))
				ver_d = data_byte;
			if (hdr_q == HDR_IW'(POS_FLAGS))
				flags_d = data_byte;
			for (int j = 0; j < 8; j++)
				if (hdr_q == HDR_IW'(POS_GRANULE + j))
					gran_d[j*8 +: 8] = data_byte;
			for (int j = 0; j < 4; j++) begin
				if (hdr_q == HDR_IW'(POS_SERIAL + j))
					serial_d[j*8 +: 8] = data_byte;
				if (hdr_q == HDR_IW'(POS_SEQUENCE + j))
					seqn_d[j*8 +: 8] = data_byte;
				if (hdr_q == HDR_IW'(POS_CHECKSUM + j))
					crc_d[j*8 +: 8] = data_byte;
			end
			if (hdr_q == HDR_IW'(POS_COUNT))
				total_d = data_byte;
			if (stat.hdr_last)
				seg_d = '0;
		end

		if (cmd.tbl_wr && !stat.tbl_last)
			seg_d = seg_q + 8'd1;

		if (cmd.scan_hit) begin
			seg_d = scan_q[7:0];
			rem_d = rdata_q;
		end

		if (cmd.pay_dec)
			rem_d = stat.seg_end ? 8'd0 : rem_q - 8'd1;

		if (cmd.scan_start)
			scan_d = cmd.scan_from_next ? {1'b0, seg_q} + SCAN_W'(1) : '0;
		if (cmd.scan_adv)
			scan_d = scan_q + SCAN_W'(1);

		if (cmd.take && (cnt_q != 32'hFFFF_FFFF))
			cnt_d = cnt_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q    <= '0;
			hdr_q    <= '0;
			total_q  <= '0;
			seg_q    <= '0;
			rem_q    <= '0;
			scan_q   <= '0;
			ver_q    <= '0;
			flags_q  <= '0;
			gran_q   <= '0;
			serial_q <= '0;
			seqn_q   <= '0;
			crc_q    <= '0;
			cnt_q    <= '0;
		end else if (cmd.clear) begin
			sig_q    <= '0;
			hdr_q    <= '0;
			total_q  <= '0;
			seg_q    <= '0;
			rem_q    <= '0;
			scan_q   <= '0;
			ver_q    <= '0;
			flags_q  <= '0;
			gran_q   <= '0;
			serial_q <= '0;
			seqn_q   <= '0;
			crc_q    <= '0;
			cnt_q    <= '0;
		end else begin
			sig_q    <= sig_d;
			hdr_q    <= hdr_d;
			total_q  <= total_d;
			seg_q    <= seg_d;
			rem_q    <= rem_d;
			scan_q   <= scan_d;
			ver_q    <= ver_d;
			flags_q  <= flags_d;
			gran_q   <= gran_d;
			serial_q <= serial_d;
			seqn_q   <= seqn_d;
			crc_q    <= crc_d;
			cnt_q    <= cnt_d;
		end
	end

	// segment table store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && ({1'b0, seg_q} < SCAN_W'(MAX_SEGMENTS)))
			seg_mem[seg_q[SEG_AW-1:0]] <= data_byte;
		if (cmd.scan_rd)
			rdata_q <= seg_mem[scan_q[SEG_AW-1:0]];
	end

	// result register takes the values before any end-of-data clear
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			res.payload_byte     <= data_byte;
			res.version          <= ver_d;
			res.header_type      <= flags_d;
			res.granule_position <= gran_d;
			res.serial_number    <= serial_d;
			res.sequence_number  <= seqn_d;
			res.checksum         <= crc_d;
			res.segment_count    <= total_d;
			res.bytes_consumed   <= cnt_d;
			res_ev               <= cmd.ev;
			res_eos              <= cmd.eos;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/opd_ctrl.sv =====
`default_nettype none

module opd_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	input  wire             in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  wire             out_ready,
	input  opd_pkg::stat_t  stat,
	output opd_pkg::cmd_t   cmd
);
	import opd_pkg::*;

	phase_t phase_q, phase_d;
	logic   ovalid_q;
	logic   room;
	logic   fire;

	assign room      = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			ovalid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (cmd.take)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		cmd      = '0;
		cmd.ev   = EV_HEADER;
		in_ready = 1'b0;
		fire     = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				in_ready = room;
				fire     = in_valid && room;
				if (fire) begin
					cmd.take   = 1'b1;
					cmd.hdr_wr = 1'b1;
					if (stat.hdr_last) begin
						if (stat.byte_zero) begin
							cmd.ev         = EV_DONE;
							cmd.scan_start = 1'b1;
							phase_d        = PH_SCAN_RD;
						end else begin
							phase_d = PH_TABLE;
						end
					end
				end
			end
			PH_TABLE: begin
				in_ready = room;
				fire     = in_valid && room;
				if (fire) begin
					cmd.take   = 1'b1;
					cmd.tbl_wr = 1'b1;
					if (stat.tbl_last) begin
						cmd.ev         = EV_DONE;
						cmd.scan_start = 1'b1;
						phase_d        = PH_SCAN_RD;
					end
				end
			end
			PH_PAYLOAD: begin
				in_ready = room;
				fire     = in_valid && room;
				if (fire) begin
					cmd.take    = 1'b1;
					cmd.ev      = EV_PAYLOAD;
					cmd.pay_dec = 1'b1;
					if (stat.seg_end) begin
						cmd.eos            = 1'b1;
						cmd.scan_start     = 1'b1;
						cmd.scan_from_next = 1'b1;
						phase_d            = PH_SCAN_RD;
					end
				end
			end
			PH_SCAN_RD: begin
				if (stat.scan_end) begin
					cmd.sig_op = SIG_CLR;
					phase_d    = PH_HUNT;
				end else begin
					cmd.scan_rd = 1'b1;
					phase_d     = PH_SCAN_CHK;
				end
			end
			PH_SCAN_CHK: begin
				if (stat.scan_hit) begin
					cmd.scan_hit = 1'b1;
					phase_d      = PH_PAYLOAD;
				end else begin
					cmd.scan_adv = 1'b1;
					phase_d      = PH_SCAN_RD;
				end
			end
			default: begin
				in_ready = room;
				fire     = in_valid && room;
				if (fire) begin
					cmd.take = 1'b1;
					if (stat.sig_match) begin
						if (stat.sig_last) begin
							cmd.sig_op = SIG_CLR;
							phase_d    = PH_HEADER;
						end else begin
							cmd.sig_op = SIG_ADV;
							phase_d    = PH_HUNT;
						end
					end else begin
						cmd.ev     = EV_BADSIG;
						cmd.sig_op = SIG_BAD;
						phase_d    = PH_HUNT;
					end
				end
			end
		endcase

		// end of buffer: report the byte, then back to the reset state
		if (fire && in_last) begin
			cmd.clear = 1'b1;
			phase_d   = PH_HUNT;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_take_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SCAN_RD || phase_q == PH_SCAN_CHK) |-> !cmd.take)
		else $error("byte taken during segment scan");

	a_take_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (!ovalid_q || out_ready))
		else $error("result register overwritten");

	a_hit_to_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_hit && !cmd.clear) |=> (phase_q == PH_PAYLOAD))
		else $error("segment found but payload phase not entered");

	a_last_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && in_last) |=> (phase_q == PH_HUNT))
		else $error("end of data did not restart the hunt");

	a_one_datapath_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.hdr_wr, cmd.tbl_wr, cmd.pay_dec, cmd.scan_rd,
		          cmd.scan_adv, cmd.scan_hit}))
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// ===== rtl/ogg_page_deframer.sv =====
// Channel   Direction  Beat contents
// s_axis    in         tdata: data_byte; tlast: end_of_data
// m_axis    out        tdata: page fields and byte count; tuser: event_res;
//                      tlast: end_of_segment
//
// One result per input byte, one byte per cycle while the result register drains.
// After the last byte of a segment, or the end of a page header, a scan of the
// segment table store looks for the next nonzero entry, reading and then checking each
// entry (each store read is registered); no byte is taken meanwhile.
// Reset is asynchronous and leaves the parser hunting for the capture pattern.
// m_axis_tready low holds the result and stalls s_axis once the register is full.
`default_nettype none

module ogg_page_deframer (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  wire          s_axis_tlast,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [223:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] version,
	                                     // [23:16] header_type, [87:24] granule_position,
	                                     // [119:88] serial_number, [151:120] sequence_number,
	                                     // [183:152] checksum, [191:184] segment_count,
	                                     // [223:192] bytes_consumed
	output logic [1:0]   m_axis_tuser,   // [1:0] event_res
	output logic         m_axis_tlast
);
	import opd_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	res_t  res;

	opd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	opd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res),
		.res_ev    (m_axis_tuser),
		.res_eos   (m_axis_tlast)
	);

	assign m_axis_tdata = res;

endmodule

`default_nettype wire
